/* design/rhcc_pkg.sv */
package rhcc_pkg;

   // number format
   localparam int COMPONENT_BITS    = 12;
   localparam int HUE_FRACTION_BITS = 6;
   localparam int TOLERANCE         = 1;

   localparam int CW     = COMPONENT_BITS + 1;
   localparam int HW     = 9 + HUE_FRACTION_BITS;
   localparam int ONE    = 1 << COMPONENT_BITS;
   localparam int SECTOR = 60 << HUE_FRACTION_BITS;
   localparam int FULL   = 360 << HUE_FRACTION_BITS;

   // divider: quotient bits and numerator width
   localparam int SQW = $clog2(SECTOR + 1);
   localparam int QW  = (CW > SQW) ? CW : SQW;
   localparam int NW  = QW + CW;

   // hsv to rgb: division by ONE * SECTOR = 15 << DEN_SHIFT
   // (sixty is fifteen times four, hence the extra two bits)
   localparam int      DEN_SHIFT = COMPONENT_BITS + HUE_FRACTION_BITS + 2;
   localparam int      DW        = DEN_SHIFT + 4;
   localparam longint  DEN       = longint'(ONE) * longint'(SECTOR);
   localparam int      PW        = CW + DW;
   localparam int      YW        = CW + 4;
   localparam int      RK        = CW + 9;
   localparam longint  RM        = ((longint'(1) << RK) + 14) / 15;
   localparam int      RMW       = RK - 3;
   localparam int      MW        = YW + RMW;

   // operation codes
   localparam logic OP_TO_HSV = 1'b0;
   localparam logic OP_TO_RGB = 1'b1;

   // hue sectors
   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;
   localparam logic [2:0] SEC_MAG_RED = 3'd5;

   typedef struct packed {
      logic          op;
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
      logic [HW-1:0] hue;
      logic          hue_undefined;
      logic [CW-1:0] saturation;
      logic [CW-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [CW-1:0] out_red;
      logic [CW-1:0] out_green;
      logic [CW-1:0] out_blue;
      logic [HW-1:0] out_hue;
      logic          out_hue_undefined;
      logic [CW-1:0] out_saturation;
      logic [CW-1:0] out_brightness;
   } rsp_type;

   // state carried through the divider stages
   typedef struct packed {
      logic          op;
      logic          grey_flag;
      logic          sat_zero;
      logic [CW-1:0] val;
      logic [CW-1:0] delta;
      logic [HW-1:0] base;
      logic          neg;
      logic [CW-1:0] sat_rem;
      logic [QW-1:0] sat_lo;
      logic [QW-1:0] sat_q;
      logic [CW-1:0] hue_rem;
      logic [QW-1:0] hue_lo;
      logic [QW-1:0] hue_q;
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
   } pipe_type;

endpackage

/* design/rhcc_if.sv */
interface rhcc_req_if;
   import rhcc_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rhcc_rsp_if;
   import rhcc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/rhcc_front.sv */
module rhcc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  rhcc_pkg::req_type  in_req,
   output logic               out_valid,
   output rhcc_pkg::pipe_type out_pipe
);
   import rhcc_pkg::*;

   localparam logic [1:0] IDX_RED   = 2'd0;
   localparam logic [1:0] IDX_GREEN = 2'd1;
   localparam logic [1:0] IDX_BLUE  = 2'd2;

   typedef struct packed {
      logic            op;
      logic            grey_flag;
      logic            sat_zero;
      logic [CW-1:0]   val;
      logic [CW-1:0]   delta;
      logic [CW-1:0]   mag;
      logic [HW-1:0]   base;
      logic            neg;
      logic [NW-1:0]   sat_num;
      logic [NW-1:0]   hue_num;
      logic            undef;
      logic [HW-1:0]   hn;
      logic [CW-1:0]   sat;
      logic [CW-1:0]   bri;
      logic [2:0]      sec;
      logic [DW-1:0]   sf;
      logic [DW-1:0]   srest;
      logic [2*CW-1:0] pprod;
      logic [PW-1:0]   qprod;
      logic [PW-1:0]   tprod;
      logic [MW-1:0]   qm;
      logic [MW-1:0]   tm;
   } fr_type;

   fr_type   stg_ff [4];
   fr_type   stg_in [4];
   logic     vld_ff [4];
   pipe_type out_ff;
   pipe_type out_in;
   logic     out_vld_ff;

   function automatic logic near_one(input logic [CW-1:0] x);
      near_one = (int'(x) < ONE + TOLERANCE) && (int'(x) > ONE - TOLERANCE);
   endfunction

   // stage 1: max, min and grey tests; hue wrap and saturation clamp
   always_comb begin
      logic [CW-1:0] mxv;
      logic [CW-1:0] mnv;
      logic [1:0]    mxi;
      logic [CW-1:0] ca;
      logic [CW-1:0] cb;
      logic          blk;
      logic          wht;
      stg_in[0] = '0;
      mxv = in_req.red;
      mxi = IDX_RED;
      mnv = in_req.red;
      if (in_req.green > mxv) begin
         mxv = in_req.green;
         mxi = IDX_GREEN;
      end
      if (in_req.blue > mxv) begin
         mxv = in_req.blue;
         mxi = IDX_BLUE;
      end
      if (in_req.green < mnv) mnv = in_req.green;
      if (in_req.blue < mnv) mnv = in_req.blue;
      case (mxi)
         IDX_RED: begin
            ca = in_req.green;
            cb = in_req.blue;
            stg_in[0].base = '0;
         end
         IDX_GREEN: begin
            ca = in_req.blue;
            cb = in_req.red;
            stg_in[0].base = HW'(2 * SECTOR);
         end
         default: begin
            ca = in_req.red;
            cb = in_req.green;
            stg_in[0].base = HW'(4 * SECTOR);
         end
      endcase
      blk = (int'(in_req.red) < TOLERANCE) && (int'(in_req.green) < TOLERANCE)
            && (int'(in_req.blue) < TOLERANCE);
      wht = near_one(in_req.red) && near_one(in_req.green) && near_one(in_req.blue);
      stg_in[0].op        = in_req.op;
      stg_in[0].delta     = mxv - mnv;
      stg_in[0].neg       = ca < cb;
      stg_in[0].mag       = (ca < cb) ? cb - ca : ca - cb;
      stg_in[0].val       = blk ? '0 : (wht ? CW'(ONE) : mxv);
      stg_in[0].sat_zero  = blk || wht || (int'(mxv) < TOLERANCE);
      stg_in[0].grey_flag = blk || wht || (mxv == mnv);
      stg_in[0].undef     = in_req.hue_undefined;
      stg_in[0].bri       = in_req.brightness;
      stg_in[0].sat       = (in_req.saturation > CW'(ONE)) ? CW'(ONE) : in_req.saturation;
      if ((int'(in_req.hue) < FULL + TOLERANCE) && (int'(in_req.hue) > FULL - TOLERANCE))
         stg_in[0].hn = '0;
      else if (in_req.hue >= HW'(FULL))
         stg_in[0].hn = in_req.hue - HW'(FULL);
      else
         stg_in[0].hn = in_req.hue;
   end

   // stage 2: divider numerators; sector, fraction and first products
   always_comb begin
      logic [HW-1:0] f;
      stg_in[1] = stg_ff[0];
      stg_in[1].sat_num = NW'(stg_ff[0].delta) << COMPONENT_BITS;
      stg_in[1].hue_num = NW'(stg_ff[0].mag) * NW'(SECTOR);
      stg_in[1].sec = SEC_RED_YEL;
      for (int k = 1; k < 6; k++) begin
         if (stg_ff[0].hn >= HW'(k * SECTOR)) stg_in[1].sec = 3'(k);
      end
      f = stg_ff[0].hn - HW'(int'(stg_in[1].sec) * SECTOR);
      stg_in[1].sf    = DW'(stg_ff[0].sat) * DW'(f);
      stg_in[1].srest = DW'(stg_ff[0].sat) * (DW'(SECTOR) - DW'(f));
      stg_in[1].pprod = (2*CW)'(stg_ff[0].bri) * (2*CW)'(CW'(ONE) - stg_ff[0].sat);
   end

   // stage 3: v times the remaining numerators
   always_comb begin
      stg_in[2] = stg_ff[1];
      stg_in[2].qprod = PW'(stg_ff[1].bri) * PW'(DW'(DEN) - stg_ff[1].sf);
      stg_in[2].tprod = PW'(stg_ff[1].bri) * PW'(DW'(DEN) - stg_ff[1].srest);
   end

   // stage 4: divide by fifteen through a reciprocal
   always_comb begin
      stg_in[3] = stg_ff[2];
      stg_in[3].qm = MW'(YW'(stg_ff[2].qprod >> DEN_SHIFT)) * MW'(RM);
      stg_in[3].tm = MW'(YW'(stg_ff[2].tprod >> DEN_SHIFT)) * MW'(RM);
   end

   // stage 5: sector select and divider set-up
   always_comb begin
      logic [CW-1:0] pv;
      logic [CW-1:0] qv;
      logic [CW-1:0] tv;
      logic [CW-1:0] vv;
      pv = CW'(stg_ff[3].pprod >> COMPONENT_BITS);
      qv = CW'(stg_ff[3].qm >> RK);
      tv = CW'(stg_ff[3].tm >> RK);
      vv = stg_ff[3].bri;
      out_in = '0;
      out_in.op        = stg_ff[3].op;
      out_in.grey_flag = stg_ff[3].grey_flag;
      out_in.sat_zero  = stg_ff[3].sat_zero;
      out_in.val       = stg_ff[3].val;
      out_in.delta     = stg_ff[3].delta;
      out_in.base      = stg_ff[3].base;
      out_in.neg       = stg_ff[3].neg;
      out_in.sat_rem   = CW'(stg_ff[3].sat_num >> QW);
      out_in.sat_lo    = stg_ff[3].sat_num[QW-1:0];
      out_in.hue_rem   = CW'(stg_ff[3].hue_num >> QW);
      out_in.hue_lo    = stg_ff[3].hue_num[QW-1:0];
      if (stg_ff[3].undef) begin
         out_in.red   = vv;
         out_in.green = vv;
         out_in.blue  = vv;
      end else begin
         case (stg_ff[3].sec)
            SEC_RED_YEL: begin
               out_in.red = vv; out_in.green = tv; out_in.blue = pv;
            end
            SEC_YEL_GRN: begin
               out_in.red = qv; out_in.green = vv; out_in.blue = pv;
            end
            SEC_GRN_CYN: begin
               out_in.red = pv; out_in.green = vv; out_in.blue = tv;
            end
            SEC_CYN_BLU: begin
               out_in.red = pv; out_in.green = qv; out_in.blue = vv;
            end
            SEC_BLU_MAG: begin
               out_in.red = tv; out_in.green = pv; out_in.blue = vv;
            end
            SEC_MAG_RED: begin
               out_in.red = vv; out_in.green = pv; out_in.blue = qv;
            end
            default: begin
               out_in.red = vv; out_in.green = pv; out_in.blue = qv;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff[0] <= stg_in[0];
         for (int i = 1; i < 4; i++) stg_ff[i] <= stg_in[i];
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) vld_ff[i] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) vld_ff[i] <= vld_ff[i-1];
         out_vld_ff <= vld_ff[3];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_pipe  = out_ff;

endmodule

/* design/rhcc_div_step.sv */
module rhcc_div_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  rhcc_pkg::pipe_type in_pipe,
   output logic               out_valid,
   output rhcc_pkg::pipe_type out_pipe
);
   import rhcc_pkg::*;

   pipe_type pipe_ff;
   pipe_type pipe_in;
   logic     vld_ff;

   // one restoring step for each of the two quotients
   always_comb begin
      logic [CW:0] sw;
      logic [CW:0] hw;
      pipe_in = in_pipe;
      sw = {in_pipe.sat_rem, in_pipe.sat_lo[QW-1]};
      hw = {in_pipe.hue_rem, in_pipe.hue_lo[QW-1]};
      pipe_in.sat_lo = in_pipe.sat_lo << 1;
      pipe_in.hue_lo = in_pipe.hue_lo << 1;
      if (sw >= {1'b0, in_pipe.val}) begin
         pipe_in.sat_rem = CW'(sw - {1'b0, in_pipe.val});
         pipe_in.sat_q   = {in_pipe.sat_q[QW-2:0], 1'b1};
      end else begin
         pipe_in.sat_rem = CW'(sw);
         pipe_in.sat_q   = {in_pipe.sat_q[QW-2:0], 1'b0};
      end
      if (hw >= {1'b0, in_pipe.delta}) begin
         pipe_in.hue_rem = CW'(hw - {1'b0, in_pipe.delta});
         pipe_in.hue_q   = {in_pipe.hue_q[QW-2:0], 1'b1};
      end else begin
         pipe_in.hue_rem = CW'(hw);
         pipe_in.hue_q   = {in_pipe.hue_q[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) pipe_ff <= pipe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_valid;
      end
   end

   assign out_valid = vld_ff;
   assign out_pipe  = pipe_ff;

endmodule

/* design/rgb_hsv_colour_converter.sv */
// path from an accepted request to its result on rsp_chan:
// 5 front stages, 13 divider stages, 1 output register
// throughput: one request per cycle; the whole pipe holds while a result waits
// reset: synchronous, active high; clears the valid bits of every stage only
module rgb_hsv_colour_converter (
   input  logic       clock,
   input  logic       reset,
   rhcc_req_if.sink   req_chan,
   rhcc_rsp_if.source rsp_chan
);
   import rhcc_pkg::*;

   // pipe moves when the output register is empty or being drained
   logic     advance;
   pipe_type dv_pipe [QW+1];
   logic     dv_vld  [QW+1];
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     rsp_valid_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // component maths for both directions, then divider set-up
   rhcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_req    (req_chan.payload),
      .out_valid (dv_vld[0]),
      .out_pipe  (dv_pipe[0])
   );

   // saturation and hue quotients, one bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_div
      rhcc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_vld[i]),
         .in_pipe   (dv_pipe[i]),
         .out_valid (dv_vld[i+1]),
         .out_pipe  (dv_pipe[i+1])
      );
   end

   // final hue assembly and field selection by operation
   always_comb begin
      logic [CW-1:0]        sat;
      logic                 undef;
      logic [HW-1:0]        qh;
      logic signed [HW+1:0] hs;
      sat   = dv_pipe[QW].sat_zero ? '0 : CW'(dv_pipe[QW].sat_q);
      undef = dv_pipe[QW].grey_flag || (int'(sat) < TOLERANCE);
      qh    = HW'(dv_pipe[QW].hue_q);
      hs    = $signed({2'b00, dv_pipe[QW].base});
      if (dv_pipe[QW].neg) hs = hs - $signed({2'b00, qh});
      else hs = hs + $signed({2'b00, qh});
      // red sector can fall below zero: wrap once round the circle
      if (hs < 0) hs = hs + $signed((HW+2)'(FULL));
      rsp_in = '0;
      if (dv_pipe[QW].op == OP_TO_RGB) begin
         rsp_in.out_red   = dv_pipe[QW].red;
         rsp_in.out_green = dv_pipe[QW].green;
         rsp_in.out_blue  = dv_pipe[QW].blue;
      end else begin
         rsp_in.out_hue_undefined = undef;
         rsp_in.out_hue           = undef ? '0 : hs[HW-1:0];
         rsp_in.out_saturation    = sat;
         rsp_in.out_brightness    = dv_pipe[QW].val;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_vld[QW];
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

`ifndef SYNTHESIS
   // a waiting result must hold the request side off
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while result stalled");

   // an undefined hue reports as zero
   a_undef_hue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.out_hue_undefined |->
      rsp_chan.payload.out_hue == '0)
      else $error("undefined hue not zero");

   // results with non-zero rgb fields carry no saturation, brightness or undefined flag
   a_rgb_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.out_red != '0 ||
      rsp_chan.payload.out_green != '0 || rsp_chan.payload.out_blue != '0) |->
      rsp_chan.payload.out_saturation == '0 && rsp_chan.payload.out_brightness == '0 &&
      !rsp_chan.payload.out_hue_undefined)
      else $error("mixed result fields");

   // quotients stay within range
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.payload.out_saturation <= CW'(ONE) &&
      rsp_chan.payload.out_hue < HW'(FULL))
      else $error("quotient out of range");
`endif

endmodule
